>>> rtl/bvg_pkg.sv
// shared types, widths and constants for the battery voltage gauge
// no dependencies

package bvg_pkg;

  localparam int unsigned OVERSAMPLE_COUNT_DEF = 16;
  localparam int unsigned OVERSAMPLE_MAX       = 16;

  localparam int unsigned PIN_W  = 12;
  localparam int unsigned MV_W   = 13;
  localparam int unsigned PCT_W  = 7;
  localparam int unsigned WGT_W  = 9;
  localparam int unsigned SUM_W  = 16;
  localparam int unsigned FRAC_W = 8;
  localparam int unsigned V_W    = MV_W + FRAC_W;
  localparam int unsigned ALU_W  = 31;
  localparam int unsigned MUL_STEPS = WGT_W;
  localparam int unsigned STEP_W = $clog2(MUL_STEPS);

  // reciprocal scaling of the group sum: exact floor for every sum of up to the largest group
  localparam int unsigned RECIP_SH = SUM_W + $clog2(OVERSAMPLE_MAX);
  localparam int unsigned RECIP_W  = FRAC_W + 2 + RECIP_SH;

  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 24;
  localparam int unsigned REG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = MV_W;

  localparam logic [REG_IDX_W-1:0] REG_EMPTY  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_FULL   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_USB    = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_WEIGHT = 2'd3;

  localparam logic [MV_W-1:0]  EMPTY_RST  = 13'd3300;
  localparam logic [MV_W-1:0]  FULL_RST   = 13'd4200;
  localparam logic [MV_W-1:0]  USB_RST    = 13'd4350;
  localparam logic [WGT_W-1:0] WEIGHT_RST = 9'd51;

  localparam logic [WGT_W-1:0] WEIGHT_ONE = 9'd256;
  localparam logic [WGT_W-1:0] PCT_SCALE  = 9'd200;
  localparam logic [PCT_W-1:0] PCT_FULL   = 7'd100;
  localparam logic [PCT_W-1:0] PCT_EMPTY  = 7'd0;

  typedef struct packed {
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
    logic             sub;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0] sum;
    logic             neg;
    logic             zero;
  } alu_rsp_t;

  typedef struct packed {
    logic [MV_W-1:0]  empty_mv;
    logic [MV_W-1:0]  full_mv;
    logic [MV_W-1:0]  usb_mv;
    logic [WGT_W-1:0] weight;
  } cfg_t;

  typedef struct packed {
    logic             usb_power;
    logic [PCT_W-1:0] charge_percent;
    logic [MV_W-1:0]  battery_millivolts;
  } res_t;

endpackage

>>> rtl/bvg_alu.sv
// shared add / subtract unit with sign and zero flags
// depends on bvg_pkg

module bvg_alu (
  input  bvg_pkg::alu_req_t req_i,
  output bvg_pkg::alu_rsp_t rsp_o
);
  import bvg_pkg::*;

  logic [ALU_W-1:0] b_op;
  logic [ALU_W-1:0] sum;

  assign b_op = req_i.sub ? ~req_i.b : req_i.b;
  assign sum  = req_i.a + b_op + ALU_W'(req_i.sub);

  assign rsp_o.sum  = sum;
  assign rsp_o.neg  = sum[ALU_W-1];
  assign rsp_o.zero = (sum == '0);

endmodule

>>> rtl/bvg_core.sv
// sequencer and datapath registers: accumulation, reciprocal sample scaling, ema,
// percent multiply / divide and threshold compares, all but the sample scaling on one shared alu
// depends on bvg_pkg and bvg_alu

module bvg_core #(
  parameter int unsigned OVERSAMPLE_COUNT = bvg_pkg::OVERSAMPLE_COUNT_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [bvg_pkg::PIN_W-1:0] pin_i,
  input  bvg_pkg::cfg_t             cfg_i,
  output logic                      res_valid_o,
  input  logic                      res_ready_i,
  output bvg_pkg::res_t             res_o
);
  import bvg_pkg::*;

  localparam int unsigned CNT_W = (OVERSAMPLE_COUNT > 1) ? $clog2(OVERSAMPLE_COUNT) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(OVERSAMPLE_COUNT - 1);
  localparam longint unsigned RECIP_NUM = 64'd1 << (FRAC_W + 1 + RECIP_SH);
  localparam logic [RECIP_W-1:0] SAMPLE_RECIP =
    RECIP_W'((RECIP_NUM + OVERSAMPLE_COUNT - 1) / OVERSAMPLE_COUNT);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SDIV, ST_SUBV, ST_EMUL, ST_DIFFE, ST_DIFFF,
    ST_SPAN, ST_PMUL, ST_PDIV, ST_USB, ST_DONE
  } state_e;

  state_e            state_q, state_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [V_W-1:0]    v_q, v_d;
  logic              primed_q, primed_d;
  logic [ALU_W-1:0]  rem_q, rem_d;
  logic [ALU_W-1:0]  dsr_q, dsr_d;
  logic [ALU_W-1:0]  md_q, md_d;
  logic [V_W-1:0]    quot_q, quot_d;
  logic [WGT_W-1:0]  mul_q, mul_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [PCT_W-1:0]  pct_q, pct_d;
  logic              usb_q, usb_d;

  alu_req_t          req;
  alu_rsp_t          rsp;
  logic [ALU_W-1:0]  v_ext, e_ext, f_ext, u_ext;
  logic              take, last;
  logic [V_W-1:0]    quot_nx;
  logic [ALU_W-1:0]  rem_div, acc_nx;
  logic [SUM_W+RECIP_W-1:0] sample_prod;

  bvg_alu u_alu (
    .req_i (req),
    .rsp_o (rsp)
  );

  assign v_ext = ALU_W'(v_q);
  assign e_ext = ALU_W'({cfg_i.empty_mv, FRAC_W'(0)});
  assign f_ext = ALU_W'({cfg_i.full_mv, FRAC_W'(0)});
  assign u_ext = ALU_W'({cfg_i.usb_mv, FRAC_W'(0)});

  // group sum times a constant reciprocal
  assign sample_prod = {{RECIP_W{1'b0}}, rem_q[SUM_W-1:0]} * {{SUM_W{1'b0}}, SAMPLE_RECIP};

  assign take    = !rsp.neg;
  assign quot_nx = {quot_q[V_W-2:0], take};
  assign rem_div = take ? rsp.sum : rem_q;
  assign acc_nx  = mul_q[0] ? rsp.sum : rem_q;
  assign last    = (step_q == '0);

  always_comb begin
    req.a   = ALU_W'(sum_q);
    req.b   = ALU_W'(pin_i);
    req.sub = 1'b0;
    case (state_q)
      ST_PDIV: begin
        req.a = rem_q; req.b = dsr_q; req.sub = 1'b1;
      end
      ST_SUBV: begin
        req.a = ALU_W'(quot_q); req.b = v_ext; req.sub = 1'b1;
      end
      ST_EMUL, ST_PMUL: begin
        req.a = rem_q; req.b = md_q;
      end
      ST_DIFFE: begin
        req.a = v_ext; req.b = e_ext; req.sub = 1'b1;
      end
      ST_DIFFF: begin
        req.a = v_ext; req.b = f_ext; req.sub = 1'b1;
      end
      ST_SPAN: begin
        req.a = f_ext; req.b = e_ext; req.sub = 1'b1;
      end
      ST_USB: begin
        req.a = v_ext; req.b = u_ext; req.sub = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d  = state_q;
    sum_d    = sum_q;
    cnt_d    = cnt_q;
    v_d      = v_q;
    primed_d = primed_q;
    rem_d    = rem_q;
    dsr_d    = dsr_q;
    md_d     = md_q;
    quot_d   = quot_q;
    mul_d    = mul_q;
    step_d   = step_q;
    pct_d    = pct_q;
    usb_d    = usb_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          sum_d = rsp.sum[SUM_W-1:0];
          if (cnt_q == CNT_LAST) begin
            cnt_d   = '0;
            sum_d   = '0;
            rem_d   = ALU_W'(rsp.sum[SUM_W-1:0]);
            state_d = ST_SDIV;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      ST_SDIV: begin
        quot_d  = sample_prod[RECIP_SH +: V_W];
        state_d = ST_SUBV;
      end
      ST_PDIV: begin
        rem_d  = rem_div;
        quot_d = quot_nx;
        dsr_d  = dsr_q >> 1;
        step_d = step_q - 1'b1;
        if (last) begin
          pct_d   = quot_nx[PCT_W-1:0];
          state_d = ST_USB;
        end
      end
      ST_SUBV: begin
        if (!primed_q) begin
          v_d      = quot_q;
          primed_d = 1'b1;
          state_d  = ST_DIFFE;
        end else begin
          md_d    = rsp.sum;
          rem_d   = ALU_W'({v_q, FRAC_W'(0)});
          mul_d   = (cfg_i.weight > WEIGHT_ONE) ? WEIGHT_ONE : cfg_i.weight;
          step_d  = STEP_W'(MUL_STEPS - 1);
          state_d = ST_EMUL;
        end
      end
      ST_EMUL, ST_PMUL: begin
        rem_d  = acc_nx;
        md_d   = md_q << 1;
        mul_d  = mul_q >> 1;
        step_d = step_q - 1'b1;
        if (last) begin
          if (state_q == ST_EMUL) begin
            v_d     = acc_nx[V_W+FRAC_W-1:FRAC_W];
            state_d = ST_DIFFE;
          end else begin
            quot_d  = '0;
            step_d  = STEP_W'(PCT_W - 1);
            state_d = ST_PDIV;
          end
        end
      end
      ST_DIFFE: begin
        if (rsp.neg || rsp.zero) begin
          pct_d   = PCT_EMPTY;
          state_d = ST_USB;
        end else begin
          md_d    = rsp.sum;
          state_d = ST_DIFFF;
        end
      end
      ST_DIFFF: begin
        if (!rsp.neg) begin
          pct_d   = PCT_FULL;
          state_d = ST_USB;
        end else begin
          state_d = ST_SPAN;
        end
      end
      ST_SPAN: begin
        rem_d   = rsp.sum;
        dsr_d   = rsp.sum << PCT_W;
        mul_d   = PCT_SCALE;
        step_d  = STEP_W'(MUL_STEPS - 1);
        state_d = ST_PMUL;
      end
      ST_USB: begin
        usb_d   = !rsp.neg && !rsp.zero;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      sum_q    <= '0;
      cnt_q    <= '0;
      v_q      <= '0;
      primed_q <= 1'b0;
      rem_q    <= '0;
      dsr_q    <= '0;
      md_q     <= '0;
      quot_q   <= '0;
      mul_q    <= '0;
      step_q   <= '0;
      pct_q    <= '0;
      usb_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      sum_q    <= sum_d;
      cnt_q    <= cnt_d;
      v_q      <= v_d;
      primed_q <= primed_d;
      rem_q    <= rem_d;
      dsr_q    <= dsr_d;
      md_q     <= md_d;
      quot_q   <= quot_d;
      mul_q    <= mul_d;
      step_q   <= step_d;
      pct_q    <= pct_d;
      usb_q    <= usb_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);
  assign res_o.battery_millivolts = v_q[V_W-1:FRAC_W];
  assign res_o.charge_percent     = pct_q;
  assign res_o.usb_power          = usb_q;

endmodule

>>> rtl/battery_voltage_gauge.sv
// battery voltage gauge top level: config registers, stream ports, output register
// a reading that does not close a group leaves the input ready; after the closing reading the
// core runs sample scaling on a multiplier, then 9-step ema and percent multiplies and a 7-step
// percent divide on one shared adder; the first group skips the ema, clamped percents skip the
// multiply and divide. one result can wait in the output register, a second one holds off the input
// reset is asynchronous, active low, and restores the defaults; depends on bvg_pkg, bvg_core

module battery_voltage_gauge #(
  parameter int unsigned OVERSAMPLE_COUNT = bvg_pkg::OVERSAMPLE_COUNT_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // pin_millivolts [11:0]
  input  logic [bvg_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // battery_millivolts [12:0], charge_percent [19:13], usb_power [20]
  output logic [bvg_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  input  logic                           cfg_we_i,
  input  logic [bvg_pkg::REG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bvg_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import bvg_pkg::*;

  cfg_t                  cfg_q;
  res_t                  res;
  logic                  res_valid;
  logic                  res_ready;
  logic                  out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.empty_mv <= EMPTY_RST;
      cfg_q.full_mv  <= FULL_RST;
      cfg_q.usb_mv   <= USB_RST;
      cfg_q.weight   <= WEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_EMPTY:  cfg_q.empty_mv <= cfg_wdata_i[MV_W-1:0];
        REG_FULL:   cfg_q.full_mv  <= cfg_wdata_i[MV_W-1:0];
        REG_USB:    cfg_q.usb_mv   <= cfg_wdata_i[MV_W-1:0];
        REG_WEIGHT: cfg_q.weight   <= cfg_wdata_i[WGT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  bvg_core #(
    .OVERSAMPLE_COUNT (OVERSAMPLE_COUNT)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .pin_i       (s_axis_tdata_i[PIN_W-1:0]),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
      if (res_valid) begin
        out_data_q <= OUT_DATA_W'(res);
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

>>> rtl/bvg_checker.sv
// port-level checks for the battery voltage gauge, bound to the top level
// depends on bvg_pkg and battery_voltage_gauge

module bvg_port_checks (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid_i,
  input logic                           s_axis_tready_o,
  input logic                           m_axis_tvalid_o,
  input logic                           m_axis_tready_i,
  input logic [bvg_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);
  import bvg_pkg::*;

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // the input side only goes busy after taking a reading
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(s_axis_tready_o) |-> $past(s_axis_tvalid_i))
    else $error("input went busy without a transaction");

  a_percent_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[19:13] <= PCT_FULL)
    else $error("charge percent above full scale");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[OUT_DATA_W-1:21] == '0)
    else $error("padding bits of result not zero");

endmodule

bind battery_voltage_gauge bvg_port_checks u_bvg_port_checks (.*);

>>> verif/bvg_checker.sv
`timescale 1ns / 100ps
// checker for the battery voltage gauge: watches the reading, result and register ports,
// predicts each group result and compares it field by field with what the block sends
// depends on bvg_pkg

module bvg_checker
  import bvg_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [IN_DATA_W-1:0]  in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [OUT_DATA_W-1:0] out_data_i,
  input  logic                  cfg_we_i,
  input  logic [REG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output int                    fail_count_o,
  output int                    pending_o,
  output int                    readouts_o
);

  cfg_t                regs;
  logic [SUM_W-1:0]    group_sum;
  logic [3:0]          group_count;
  logic [V_W-1:0]      volts_q8;
  logic                primed;
  res_t                readout_q[$];

  function automatic logic [PCT_W-1:0] percent_for(input logic [V_W-1:0] v, input cfg_t c);
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned span;
    longint unsigned vv;
    lo = longint'(c.empty_mv) << FRAC_W;
    hi = longint'(c.full_mv) << FRAC_W;
    vv = v;
    // empty test first, so a full at or below empty never divides
    if (vv <= lo) return PCT_EMPTY;
    if (vv >= hi) return PCT_FULL;
    span = hi - lo;
    return PCT_W'((longint'(PCT_SCALE) * (vv - lo) + span) / (2 * span));
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t            seen;
    res_t            want;
    longint unsigned sample;
    longint unsigned wgt;
    longint unsigned next_v;
    if (!rst_ni) begin
      regs.empty_mv = EMPTY_RST;
      regs.full_mv  = FULL_RST;
      regs.usb_mv   = USB_RST;
      regs.weight   = WEIGHT_RST;
      group_sum     = '0;
      group_count   = '0;
      volts_q8      = '0;
      primed        = 1'b0;
      readout_q.delete();
      fail_count_o  = 0;
      pending_o     = 0;
      readouts_o    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_EMPTY:  regs.empty_mv = cfg_wdata_i[MV_W-1:0];
          REG_FULL:   regs.full_mv  = cfg_wdata_i[MV_W-1:0];
          REG_USB:    regs.usb_mv   = cfg_wdata_i[MV_W-1:0];
          REG_WEIGHT: regs.weight   = cfg_wdata_i[WGT_W-1:0];
          default: ;
        endcase
      end

      if (out_valid_i && out_ready_i) begin
        seen = res_t'(out_data_i[$bits(res_t)-1:0]);
        readouts_o++;
        if (readout_q.size() == 0) begin
          $error("gauge result with none outstanding: %h", out_data_i);
          fail_count_o++;
        end else begin
          want = readout_q.pop_front();
          if (seen.battery_millivolts !== want.battery_millivolts) begin
            $error("battery_millivolts: expected %0d, actual %0d",
                   want.battery_millivolts, seen.battery_millivolts);
            fail_count_o++;
          end
          if (seen.charge_percent !== want.charge_percent) begin
            $error("charge_percent: expected %0d, actual %0d",
                   want.charge_percent, seen.charge_percent);
            fail_count_o++;
          end
          if (seen.usb_power !== want.usb_power) begin
            $error("usb_power: expected %0d, actual %0d", want.usb_power, seen.usb_power);
            fail_count_o++;
          end
        end
      end

      if (in_valid_i && in_ready_i) begin
        group_sum = group_sum + SUM_W'(in_data_i[PIN_W-1:0]);
        if (int'(group_count) + 1 < OVERSAMPLE_COUNT_DEF) begin
          group_count++;
        end else begin
          // average of the group, doubled for the divider, in q13.8
          sample = group_sum;
          sample = (sample << (FRAC_W + 1)) / OVERSAMPLE_COUNT_DEF;
          group_sum   = '0;
          group_count = '0;
          if (!primed) begin
            next_v = sample;
            primed = 1'b1;
          end else begin
            wgt = (regs.weight > WEIGHT_ONE) ? WEIGHT_ONE : regs.weight;
            next_v = volts_q8;
            next_v = (next_v * (longint'(WEIGHT_ONE) - wgt) + sample * wgt) >> FRAC_W;
          end
          volts_q8 = V_W'(next_v);
          want.battery_millivolts = volts_q8[V_W-1:FRAC_W];
          want.charge_percent     = percent_for(volts_q8, regs);
          want.usb_power          = (volts_q8 > ({regs.usb_mv, {FRAC_W{1'b0}}}));
          readout_q.push_back(want);
        end
      end

      pending_o = readout_q.size();
    end
  end

endmodule

>>> verif/battery_voltage_gauge_test.sv
`timescale 1ns / 100ps
// testbench top for the battery voltage gauge: clock, reset, reading and register stimulus,
// random stalls on both streams and the final verdict
// depends on bvg_pkg, battery_voltage_gauge and bvg_checker

module battery_voltage_gauge_test;
  import bvg_pkg::*;

  localparam int PIN_MAX   = (1 << PIN_W) - 1;
  localparam int MV_MAX    = (1 << MV_W) - 1;
  localparam int WGT_MAX   = (1 << WGT_W) - 1;
  localparam int SETTLE_CY = 64;

  typedef enum int {MIX_NOISE, MIX_EMPTY, MIX_FULL, MIX_USB, MIX_ANY} mix_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  // pin_millivolts [11:0]
  logic [IN_DATA_W-1:0]  s_axis_tdata_i = '0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  // battery_millivolts [12:0], charge_percent [19:13], usb_power [20]
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic                  cfg_we_i = 1'b0;
  logic [REG_IDX_W-1:0]  cfg_idx_i = REG_EMPTY;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  int   fail_count;
  int   pending;
  int   readouts;
  int   readings = 0;
  int   settings = 0;
  int   ready_hold = 0;
  logic calm = 1'b0;
  logic gappy = 1'b0;
  cfg_t cur_cfg;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  battery_voltage_gauge u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  bvg_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_i   (s_axis_tready_o),
    .in_data_i    (s_axis_tdata_i),
    .out_valid_i  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_data_i   (m_axis_tdata_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .readouts_o   (readouts)
  );

  // result side back-pressure: short low bursts between longer ready stretches
  always @(posedge clk_i) begin
    if (calm) begin
      m_axis_tready_i <= 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold--;
    end else if (m_axis_tready_i) begin
      m_axis_tready_i <= 1'b0;
      ready_hold = $urandom_range(0, 5);
    end else begin
      m_axis_tready_i <= 1'b1;
      ready_hold = $urandom_range(0, 40);
    end
  end

  task automatic send_reading(input logic [PIN_W-1:0] mv);
    if (!calm && gappy && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= IN_DATA_W'(mv);
    do @(negedge clk_i); while (!s_axis_tready_o);
    @(posedge clk_i);
    readings++;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i); while (pending != 0);
    repeat (SETTLE_CY) @(posedge clk_i);
  endtask

  task automatic apply_setting(input cfg_t c);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_EMPTY;
    cfg_wdata_i <= c.empty_mv;
    @(posedge clk_i);
    cfg_idx_i   <= REG_FULL;
    cfg_wdata_i <= c.full_mv;
    @(posedge clk_i);
    cfg_idx_i   <= REG_USB;
    cfg_wdata_i <= c.usb_mv;
    @(posedge clk_i);
    cfg_idx_i   <= REG_WEIGHT;
    cfg_wdata_i <= CFG_DATA_W'(c.weight);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_cfg = c;
    settings++;
  endtask

  function automatic cfg_t random_setting();
    cfg_t c;
    int   a;
    int   b;
    a = $urandom_range(0, MV_MAX);
    b = $urandom_range(0, MV_MAX);
    // mostly a proper window, now and then an inverted one
    if ((a > b) == ($urandom_range(0, 4) != 0)) begin
      c.empty_mv = MV_W'(b);
      c.full_mv  = MV_W'(a);
    end else begin
      c.empty_mv = MV_W'(a);
      c.full_mv  = MV_W'(b);
    end
    c.usb_mv = MV_W'($urandom_range(0, MV_MAX));
    case ($urandom_range(0, 11))
      0:       c.weight = '0;
      1, 2:    c.weight = WGT_W'($urandom_range(WEIGHT_ONE + 1, WGT_MAX));
      default: c.weight = WGT_W'($urandom_range(1, WEIGHT_ONE));
    endcase
    return c;
  endfunction

  function automatic logic [PIN_W-1:0] near(input int centre);
    int r;
    r = centre + $urandom_range(0, 16) - 8;
    if (r < 0) r = 0;
    if (r > PIN_MAX) r = PIN_MAX;
    return PIN_W'(r);
  endfunction

  task automatic run_phase(input int n);
    mix_e mix;
    int   centre;
    mix    = MIX_NOISE;
    centre = 0;
    gappy  = ($urandom_range(0, 3) != 0);
    for (int k = 0; k < n; k++) begin
      if (k % OVERSAMPLE_COUNT_DEF == 0) begin
        mix = mix_e'($urandom_range(0, 4));
        case (mix)
          MIX_EMPTY: centre = cur_cfg.empty_mv / 2;
          MIX_FULL:  centre = cur_cfg.full_mv / 2;
          MIX_USB:   centre = cur_cfg.usb_mv / 2;
          default:   centre = $urandom_range(0, PIN_MAX);
        endcase
      end
      if (mix == MIX_NOISE) send_reading(PIN_W'($urandom_range(0, PIN_MAX)));
      else send_reading(near(centre));
    end
    s_axis_tvalid_i <= 1'b0;
    wait_drained();
  endtask

  initial begin
    cfg_t corner [4];
    corner[0] = '{empty_mv: '0, full_mv: MV_W'(8190), usb_mv: '0, weight: WEIGHT_ONE};
    corner[1] = '{empty_mv: MV_W'(8190), full_mv: MV_W'(1), usb_mv: MV_W'(8190),
                  weight: WGT_W'(1)};
    // equal window and a weight that freezes the smoothed value
    corner[2] = '{empty_mv: MV_W'(3000), full_mv: MV_W'(3000), usb_mv: MV_W'(4000),
                  weight: '0};
    // inverted window and a weight past one
    corner[3] = '{empty_mv: MV_W'(4000), full_mv: MV_W'(3500), usb_mv: MV_W'(3800),
                  weight: WGT_W'(WGT_MAX)};
    cur_cfg = '{empty_mv: EMPTY_RST, full_mv: FULL_RST, usb_mv: USB_RST, weight: WEIGHT_RST};

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // top of range loads the first group, then a zero group through the default weight
    gappy = 1'b1;
    for (int k = 0; k < 2 * OVERSAMPLE_COUNT_DEF; k++)
      send_reading(k < OVERSAMPLE_COUNT_DEF ? PIN_W'(PIN_MAX) : '0);
    s_axis_tvalid_i <= 1'b0;
    wait_drained();

    run_phase(160);
    foreach (corner[i]) begin
      apply_setting(corner[i]);
      run_phase(144);
    end
    repeat (6) begin
      apply_setting(random_setting());
      run_phase(160);
    end

    calm = 1'b1;
    apply_setting(random_setting());
    run_phase(200);

    $display("covered %0d readings, %0d gauge results, %0d register settings",
             readings, readouts, settings);
    if (fail_count == 0 && pending == 0) begin
      $display("battery_voltage_gauge_test: PASS");
    end else begin
      $display("battery_voltage_gauge_test: FAIL");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("battery_voltage_gauge_test: FAIL");
    $finish;
  end

endmodule

>>> battery_voltage_gauge.f
rtl/bvg_pkg.sv
rtl/bvg_alu.sv
rtl/bvg_core.sv
rtl/battery_voltage_gauge.sv
rtl/bvg_checker.sv
verif/bvg_checker.sv
verif/battery_voltage_gauge_test.sv
